@@ rtl/core/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg
// Shared types and constants of the voice allocator: table size, index
// widths, role codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sva_pkg;

	localparam int NUM_VOICES = 16;
	localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SEL_W      = 4;
	localparam int NOTE_W     = 7;
	localparam int ROLE_W     = 2;
	localparam int STAMP_W    = 32;

	localparam logic [ROLE_W-1:0] ROLE_NORMAL  = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_DESCANT = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_PEDAL   = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FIND  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN_FREE,
		S_SCAN_AGE,
		S_EMIT
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic do_write;
		logic scan_free;
		logic scan_age;
		logic load_out;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic last_entry;
		logic need_age;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/core/sva_ctrl.sv @@
// ----------------------------------------------------------------------------
// sva_ctrl
// Sequencer of the voice allocator: takes one beat at a time, writes a
// voice entry or walks the table in a free/role/note pass and, when
// stealing, an age pass, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sva_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire              op,
	output logic             out_valid,
	input  wire              out_stall,
	input  sva_pkg::status_t sts,
	output sva_pkg::cmd_t    cmd
);
	import sva_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_FIND) ? S_SCAN_FREE : S_WRITE;
				end
			end
			S_WRITE: begin
				state_d = S_EMIT;
			end
			S_SCAN_FREE: begin
				if (sts.last_entry) begin
					state_d = sts.need_age ? S_SCAN_AGE : S_EMIT;
				end
			end
			S_SCAN_AGE: begin
				if (sts.last_entry) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:      cmd.load_item = in_valid;
			S_WRITE:     cmd.do_write  = 1'b1;
			S_SCAN_FREE: cmd.scan_free = 1'b1;
			S_SCAN_AGE:  cmd.scan_age  = 1'b1;
			S_EMIT:      cmd.load_out  = slot_free;
			default:     cmd = '0;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat flag: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sva_dp.sv @@
// ----------------------------------------------------------------------------
// sva_dp
// Datapath of the voice allocator: voice status table, start stamp
// counter, scan index, search trackers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sva_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sva_pkg::cmd_t                cmd,
	output sva_pkg::status_t             sts,
	input  wire                          op,
	input  wire [sva_pkg::SEL_W-1:0]     voice_sel,
	input  wire                          set_active,
	input  wire [sva_pkg::NOTE_W-1:0]    set_note,
	input  wire                          set_key_down,
	input  wire                          set_released,
	input  wire [sva_pkg::ROLE_W-1:0]    set_role,
	input  wire                          new_start,
	input  wire                          steal_enable,
	output logic                         found,
	output logic [sva_pkg::SEL_W-1:0]    chosen_voice,
	output logic                         stolen
);
	import sva_pkg::*;

	// voice table
	logic               active_q  [NUM_VOICES];
	logic [NOTE_W-1:0]  note_q    [NUM_VOICES];
	logic               held_q    [NUM_VOICES];
	logic               release_q [NUM_VOICES];
	logic [ROLE_W-1:0]  role_q    [NUM_VOICES];
	logic [STAMP_W-1:0] stamp_q   [NUM_VOICES];
	logic [STAMP_W-1:0] counter_q;

	// latched item
	logic               op_q;
	logic [SEL_W-1:0]   sel_q;
	logic               act_q;
	logic [NOTE_W-1:0]  nnote_q;
	logic               key_q;
	logic               rel_q;
	logic [ROLE_W-1:0]  nrole_q;
	logic               start_q;
	logic               steal_q;

	// scan state and trackers
	logic [IDX_W-1:0]   idx_q;
	logic               free_v_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               desc_v_q;
	logic [IDX_W-1:0]   desc_idx_q;
	logic               ped_v_q;
	logic [IDX_W-1:0]   ped_idx_q;
	logic               low_v_q;
	logic [IDX_W-1:0]   low_idx_q;
	logic [NOTE_W-1:0]  low_note_q;
	logic               top_v_q;
	logic [IDX_W-1:0]   top_idx_q;
	logic [NOTE_W-1:0]  top_note_q;
	logic               any_v_q;
	logic [IDX_W-1:0]   any_idx_q;
	logic [STAMP_W-1:0] any_stamp_q;
	logic               kup_v_q;
	logic [IDX_W-1:0]   kup_idx_q;
	logic [STAMP_W-1:0] kup_stamp_q;

	// result register
	logic               found_q;
	logic [SEL_W-1:0]   chosen_q;
	logic               stolen_q;

	// current entry and derived terms
	logic               e_active;
	logic [NOTE_W-1:0]  e_note;
	logic               e_held;
	logic               e_release;
	logic [ROLE_W-1:0]  e_role;
	logic [STAMP_W-1:0] e_stamp;
	logic               last;
	logic               is_desc;
	logic               is_ped;
	logic               top_eff_v;
	logic               excluded;
	logic [IDX_W-1:0]   wr_idx;
	logic               wr_ok;
	logic               pick_v;
	logic [IDX_W-1:0]   pick_idx;
	logic               pick_steal;
	logic [IDX_W+SEL_W-1:0] pick_wide;

	assign e_active  = active_q[idx_q];
	assign e_note    = note_q[idx_q];
	assign e_held    = held_q[idx_q];
	assign e_release = release_q[idx_q];
	assign e_role    = role_q[idx_q];
	assign e_stamp   = stamp_q[idx_q];

	assign last    = (idx_q == IDX_W'(NUM_VOICES - 1));
	assign is_desc = e_active && (e_role == ROLE_DESCANT) && !desc_v_q;
	assign is_ped  = e_active && (e_role == ROLE_PEDAL) && !ped_v_q;

	// top note is dropped when it is the same voice as the low note
	assign top_eff_v = top_v_q && !(low_v_q && (low_idx_q == top_idx_q));
	assign excluded  = (desc_v_q && (idx_q == desc_idx_q))
	                || (ped_v_q && (idx_q == ped_idx_q))
	                || (low_v_q && (idx_q == low_idx_q))
	                || (top_eff_v && (idx_q == top_idx_q));

	assign sts.last_entry = last;
	assign sts.need_age   = steal_q && !free_v_q && e_active;

	assign wr_idx = IDX_W'(sel_q);
	assign wr_ok  = (int'(sel_q) < NUM_VOICES);

	// final choice from the trackers
	always_comb begin
		pick_v     = 1'b0;
		pick_idx   = '0;
		pick_steal = 1'b0;
		if (op_q == OP_FIND) begin
			if (free_v_q) begin
				pick_v   = 1'b1;
				pick_idx = free_idx_q;
			end else if (steal_q) begin
				// every voice is active here, so any pick cuts a voice
				pick_steal = 1'b1;
				pick_v     = 1'b1;
				if (kup_v_q) begin
					pick_idx = kup_idx_q;
				end else if (any_v_q) begin
					pick_idx = any_idx_q;
				end else if (desc_v_q) begin
					pick_idx = desc_idx_q;
				end else if (ped_v_q) begin
					pick_idx = ped_idx_q;
				end else if (top_eff_v) begin
					pick_idx = top_idx_q;
				end else if (low_v_q) begin
					pick_idx = low_idx_q;
				end else begin
					pick_v     = 1'b0;
					pick_steal = 1'b0;
				end
			end
		end
	end

	assign pick_wide = {{SEL_W{1'b0}}, pick_idx};

	// latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= op;
			sel_q   <= voice_sel;
			act_q   <= set_active;
			nnote_q <= set_note;
			key_q   <= set_key_down;
			rel_q   <= set_released;
			nrole_q <= set_role;
			start_q <= new_start;
			steal_q <= steal_enable;
		end
	end

	// update the voice table and stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				active_q[i]  <= 1'b0;
				note_q[i]    <= '0;
				held_q[i]    <= 1'b0;
				release_q[i] <= 1'b0;
				role_q[i]    <= '0;
				stamp_q[i]   <= '0;
			end
			counter_q <= STAMP_W'(1);
		end else if (cmd.do_write && wr_ok) begin
			active_q[wr_idx]  <= act_q;
			note_q[wr_idx]    <= nnote_q;
			held_q[wr_idx]    <= key_q;
			release_q[wr_idx] <= rel_q;
			role_q[wr_idx]    <= nrole_q;
			if (start_q) begin
				stamp_q[wr_idx] <= counter_q;
				counter_q       <= counter_q + STAMP_W'(1);
			end
		end
	end

	// advance the scan index, wrap after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_item) begin
			idx_q <= '0;
		end else if (cmd.scan_free || cmd.scan_age) begin
			idx_q <= last ? '0 : idx_q + IDX_W'(1);
		end
	end

	// free, role and note trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_v_q <= 1'b0;
			desc_v_q <= 1'b0;
			ped_v_q  <= 1'b0;
			low_v_q  <= 1'b0;
			top_v_q  <= 1'b0;
		end else if (cmd.load_item) begin
			free_v_q <= 1'b0;
			desc_v_q <= 1'b0;
			ped_v_q  <= 1'b0;
			low_v_q  <= 1'b0;
			top_v_q  <= 1'b0;
		end else if (cmd.scan_free) begin
			if (!e_active && !free_v_q) begin
				free_v_q   <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (is_desc) begin
				desc_v_q   <= 1'b1;
				desc_idx_q <= idx_q;
			end
			if (is_ped) begin
				ped_v_q   <= 1'b1;
				ped_idx_q <= idx_q;
			end
			if (e_active && !e_release && !is_desc && !is_ped) begin
				if (!low_v_q || (e_note < low_note_q)) begin
					low_v_q    <= 1'b1;
					low_idx_q  <= idx_q;
					low_note_q <= e_note;
				end
				if (!top_v_q || (e_note > top_note_q)) begin
					top_v_q    <= 1'b1;
					top_idx_q  <= idx_q;
					top_note_q <= e_note;
				end
			end
		end
	end

	// oldest candidate trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_v_q <= 1'b0;
			kup_v_q <= 1'b0;
		end else if (cmd.load_item) begin
			any_v_q <= 1'b0;
			kup_v_q <= 1'b0;
		end else if (cmd.scan_age && !excluded) begin
			if (!any_v_q || (e_stamp < any_stamp_q)) begin
				any_v_q     <= 1'b1;
				any_idx_q   <= idx_q;
				any_stamp_q <= e_stamp;
			end
			if (!e_held && (!kup_v_q || (e_stamp < kup_stamp_q))) begin
				kup_v_q     <= 1'b1;
				kup_idx_q   <= idx_q;
				kup_stamp_q <= e_stamp;
			end
		end
	end

	// hold the result beat until the next load
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q  <= pick_v;
			chosen_q <= pick_wide[SEL_W-1:0];
			stolen_q <= pick_steal;
		end
	end

	assign found        = found_q;
	assign chosen_voice = chosen_q;
	assign stolen       = stolen_q;

endmodule

`default_nettype wire

@@ rtl/core/synth_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Polyphonic voice allocation with voice stealing.
//
// Input channel (in_valid/in_stall) carries one beat per item: op 0 writes
// one voice entry (optionally stamping it as the newest start), op 1 asks
// for a voice for a new note. Output channel (out_valid/out_stall) returns
// one beat per item: found, chosen_voice, stolen (all zero for writes).
// A write goes from accept through the write state to the output register.
// A find walks the table one entry per cycle, once for free/role/note and,
// when it steals, once more for age. One item is in work at a time; in_stall
// is high while it is, and the next beat is taken in the cycle after the
// result loads. A result parked in the output register does not hold off the
// next accept; a later result waits in the sequencer until the receiver drops
// out_stall. Reset clears the voice table, sets the stamp counter to one
// and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_voice_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          op,
	input  wire [sva_pkg::SEL_W-1:0]     voice_sel,
	input  wire                          set_active,
	input  wire [sva_pkg::NOTE_W-1:0]    set_note,
	input  wire                          set_key_down,
	input  wire                          set_released,
	input  wire [sva_pkg::ROLE_W-1:0]    set_role,
	input  wire                          new_start,
	input  wire                          steal_enable,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         found,
	output logic [sva_pkg::SEL_W-1:0]    chosen_voice,
	output logic                         stolen
);
	import sva_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer
	sva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and search datapath
	sva_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.voice_sel    (voice_sel),
		.set_active   (set_active),
		.set_note     (set_note),
		.set_key_down (set_key_down),
		.set_released (set_released),
		.set_role     (set_role),
		.new_start    (new_start),
		.steal_enable (steal_enable),
		.found        (found),
		.chosen_voice (chosen_voice),
		.stolen       (stolen)
	);

endmodule

`default_nettype wire
